/* hdl/rrss_pkg.sv */
// Package for the round-robin slice scheduler: slot count, field widths,
// operation and status codes, slot states and the command record.
// Has no dependencies; every other file of the block imports it.
package rrss_pkg;

  localparam int SLOT_COUNT  = 16;
  localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PID_W       = 4;
  localparam int FUNC_W      = 3;
  localparam int PRIO_W      = 3;
  localparam int SLICE_W     = 6;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

  localparam logic [FUNC_W-1:0]  FUNC_CREATE = 3'd0;
  localparam logic [FUNC_W-1:0]  FUNC_TICK   = 3'd1;
  localparam logic [FUNC_W-1:0]  FUNC_BLOCK  = 3'd2;
  localparam logic [FUNC_W-1:0]  FUNC_UNBLK  = 3'd3;
  localparam logic [FUNC_W-1:0]  FUNC_ENTER  = 3'd4;
  localparam logic [FUNC_W-1:0]  FUNC_EXIT   = 3'd5;

  localparam logic [PRIO_W-1:0]  PRIO_USER = 3'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_HIGH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_USER = 1'd1;

  localparam logic [SLICE_W-1:0] SLICE_HIGH_RESET = 6'd30;
  localparam logic [SLICE_W-1:0] SLICE_USER_RESET = 6'd10;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_IN_USE = 2'd2;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_READY   = 2'd1,
    SLOT_PENDING = 2'd2
  } slot_st_t;

  typedef enum logic [2:0] {
    OP_CREATE,
    OP_TICK,
    OP_BLOCK,
    OP_UNBLOCK,
    OP_ENTER,
    OP_EXIT,
    OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CREATE,
    BK_TARGET,
    BK_SEARCH,
    BK_SWEEP,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    op_t               op;
    logic              user_class;
    logic [SLOT_W-1:0] tgt;
    logic              tgt_ok;
  } cmd_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_LAST) ? '0 : s + SLOT_W'(1);
  endfunction

endpackage

/* hdl/rrss_front.sv */
// Front end: takes request items, decodes the operation, clamps the priority
// to a user-class flag and range-checks the target slot. Uses rrss_pkg.
module rrss_front
  import rrss_pkg::*;
(
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [PRIO_W-1:0] in_priority_req,
  input  logic [PID_W-1:0]  in_target_pid,
  output logic              push_valid,
  input  logic              push_ready,
  output cmd_t              push_cmd
);

  op_t op;

  always_comb begin
    unique case (in_func)
      FUNC_CREATE: op = OP_CREATE;
      FUNC_TICK:   op = OP_TICK;
      FUNC_BLOCK:  op = OP_BLOCK;
      FUNC_UNBLK:  op = OP_UNBLOCK;
      FUNC_ENTER:  op = OP_ENTER;
      FUNC_EXIT:   op = OP_EXIT;
      default:     op = OP_NOP;
    endcase
  end

  assign push_cmd.op         = op;
  assign push_cmd.user_class = (in_priority_req >= PRIO_USER);
  assign push_cmd.tgt        = SLOT_W'(in_target_pid);
  assign push_cmd.tgt_ok     = (32'(in_target_pid) < SLOT_COUNT);

  assign push_valid = in_valid;
  assign in_stall   = !push_ready;

endmodule

/* hdl/rrss_queue.sv */
// Short command queue between the front end and the back end.
// Uses rrss_pkg for the command record and the queue depth.
module rrss_queue
  import rrss_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + QPTR_W'(1);
  endfunction

  assign push_ready = (32'(count_r) < QUEUE_DEPTH);
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule

/* hdl/rrss_back.sv */
// Back end: holds the slot table, the running slot and its slice counter,
// and carries out one command at a time with a one-slot-per-cycle scan.
// Also holds the two slice registers and the result register. Uses rrss_pkg.
module rrss_back
  import rrss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SLICE_W-1:0]   cfg_data,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  cmd_t                 pop_cmd,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  out_status,
  output logic [PID_W-1:0]     out_new_pid,
  output logic [PID_W-1:0]     out_running_pid,
  output logic                 out_running_valid,
  output logic                 out_switched
);

  bk_state_t           state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [SLOT_W-1:0]   idx_r, idx_nxt;
  logic [SLOT_W-1:0]   cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]   run_slot_r, run_slot_nxt;
  logic                run_active_r, run_active_nxt;
  logic [SLICE_W-1:0]  slice_left_r, slice_left_nxt;
  logic [SLOT_W-1:0]   old_slot_r, old_slot_nxt;
  logic                old_active_r, old_active_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]   res_pid_r, res_pid_nxt;
  logic [SLICE_W-1:0]  slice_high_r;
  logic [SLICE_W-1:0]  slice_user_r;

  slot_st_t            slot_status_r [SLOT_COUNT];
  slot_st_t            saved_status_r [SLOT_COUNT];
  logic                user_class_r [SLOT_COUNT];

  slot_st_t            cur_st;
  slot_st_t            cur_saved;
  logic                cur_user;
  logic                st_we, sv_we, cl_we;
  slot_st_t            st_wd, sv_wd;
  logic                cl_wd;
  logic                out_free;
  logic                out_load;
  logic                is_running_slot;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [PID_W-1:0]    out_new_pid_r;
  logic [PID_W-1:0]    out_running_pid_r;
  logic                out_running_valid_r;
  logic                out_switched_r;

  assign cur_st          = slot_status_r[idx_r];
  assign cur_saved       = saved_status_r[idx_r];
  assign cur_user        = user_class_r[idx_r];
  assign out_free        = !out_valid_r || !out_stall;
  assign is_running_slot = run_active_r && (idx_r == run_slot_r);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    run_slot_nxt   = run_slot_r;
    run_active_nxt = run_active_r;
    slice_left_nxt = slice_left_r;
    old_slot_nxt   = old_slot_r;
    old_active_nxt = old_active_r;
    res_status_nxt = res_status_r;
    res_pid_nxt    = res_pid_r;
    st_we          = 1'b0;
    st_wd          = SLOT_EMPTY;
    sv_we          = 1'b0;
    sv_wd          = SLOT_EMPTY;
    cl_we          = 1'b0;
    cl_wd          = 1'b0;
    pop_ready      = 1'b0;
    out_load       = 1'b0;

    unique case (state_r)
      BK_IDLE: begin
        if (pop_valid && out_free) begin
          pop_ready      = 1'b1;
          cmd_nxt        = pop_cmd;
          old_active_nxt = run_active_r;
          old_slot_nxt   = run_slot_r;
          res_status_nxt = STATUS_OK;
          res_pid_nxt    = '0;
          state_nxt      = BK_DONE;
          unique case (pop_cmd.op)
            OP_CREATE: begin
              idx_nxt   = '0;
              state_nxt = BK_CREATE;
            end
            OP_TICK: begin
              if (run_active_r) begin
                if (slice_left_r == '0) begin
                  idx_nxt   = slot_inc(run_slot_r);
                  cnt_nxt   = '0;
                  state_nxt = BK_SEARCH;
                end else begin
                  slice_left_nxt = slice_left_r - SLICE_W'(1);
                end
              end
            end
            OP_BLOCK, OP_UNBLOCK: begin
              if (!pop_cmd.tgt_ok) begin
                res_status_nxt = STATUS_NOT_IN_USE;
              end else begin
                idx_nxt   = pop_cmd.tgt;
                state_nxt = BK_TARGET;
              end
            end
            OP_ENTER, OP_EXIT: begin
              idx_nxt   = '0;
              state_nxt = BK_SWEEP;
            end
            OP_NOP: begin
            end
          endcase
        end
      end

      BK_CREATE: begin
        if (cur_st == SLOT_EMPTY) begin
          st_we       = 1'b1;
          st_wd       = SLOT_READY;
          sv_we       = 1'b1;
          sv_wd       = SLOT_EMPTY;
          cl_we       = 1'b1;
          cl_wd       = cmd_r.user_class;
          res_pid_nxt = idx_r;
          if (!run_active_r) begin
            run_slot_nxt   = idx_r;
            run_active_nxt = 1'b1;
            slice_left_nxt = cmd_r.user_class ? slice_user_r : slice_high_r;
          end
          state_nxt = BK_DONE;
        end else if (idx_r == SLOT_LAST) begin
          res_status_nxt = STATUS_FULL;
          state_nxt      = BK_DONE;
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
        end
      end

      BK_TARGET: begin
        if (cur_st == SLOT_EMPTY) begin
          res_status_nxt = STATUS_NOT_IN_USE;
          state_nxt      = BK_DONE;
        end else if (cmd_r.op == OP_BLOCK) begin
          st_we     = 1'b1;
          st_wd     = SLOT_PENDING;
          idx_nxt   = slot_inc(idx_r);
          cnt_nxt   = '0;
          state_nxt = BK_SEARCH;
        end else begin
          st_we     = 1'b1;
          st_wd     = SLOT_READY;
          state_nxt = BK_DONE;
        end
      end

      BK_SEARCH: begin
        if (cur_st == SLOT_READY) begin
          run_slot_nxt   = idx_r;
          run_active_nxt = 1'b1;
          slice_left_nxt = cur_user ? slice_user_r : slice_high_r;
          state_nxt      = BK_DONE;
        end else if (cnt_r == SLOT_LAST) begin
          run_active_nxt = 1'b0;
          slice_left_nxt = '0;
          state_nxt      = BK_DONE;
        end else begin
          idx_nxt = slot_inc(idx_r);
          cnt_nxt = cnt_r + SLOT_W'(1);
        end
      end

      BK_SWEEP: begin
        if (cur_st != SLOT_EMPTY && !is_running_slot) begin
          if (cmd_r.op == OP_ENTER) begin
            sv_we = 1'b1;
            sv_wd = cur_st;
            st_we = 1'b1;
            st_wd = SLOT_PENDING;
          end else if (cur_saved != SLOT_EMPTY) begin
            st_we = 1'b1;
            st_wd = cur_saved;
            sv_we = 1'b1;
            sv_wd = SLOT_EMPTY;
          end
        end
        if (idx_r == SLOT_LAST) begin
          state_nxt = BK_DONE;
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
        end
      end

      BK_DONE: begin
        out_load  = 1'b1;
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      run_slot_r   <= '0;
      run_active_r <= 1'b0;
      slice_left_r <= '0;
      slice_high_r <= SLICE_HIGH_RESET;
      slice_user_r <= SLICE_USER_RESET;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_status_r[i]  <= SLOT_EMPTY;
        saved_status_r[i] <= SLOT_EMPTY;
        user_class_r[i]   <= 1'b0;
      end
    end else begin
      state_r      <= state_nxt;
      run_slot_r   <= run_slot_nxt;
      run_active_r <= run_active_nxt;
      slice_left_r <= slice_left_nxt;
      if (cfg_write && cfg_index == CFG_SLICE_HIGH) slice_high_r <= cfg_data;
      if (cfg_write && cfg_index == CFG_SLICE_USER) slice_user_r <= cfg_data;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (st_we) slot_status_r[idx_r]  <= st_wd;
      if (sv_we) saved_status_r[idx_r] <= sv_wd;
      if (cl_we) user_class_r[idx_r]   <= cl_wd;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    old_slot_r   <= old_slot_nxt;
    old_active_r <= old_active_nxt;
    res_status_r <= res_status_nxt;
    res_pid_r    <= res_pid_nxt;
    if (out_load) begin
      out_status_r        <= res_status_r;
      out_new_pid_r       <= PID_W'(res_pid_r);
      out_running_pid_r   <= run_active_r ? PID_W'(run_slot_r) : '0;
      out_running_valid_r <= run_active_r;
      out_switched_r      <= (run_active_r != old_active_r) ||
                             (run_active_r && run_slot_r != old_slot_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_new_pid       = out_new_pid_r;
  assign out_running_pid   = out_running_pid_r;
  assign out_running_valid = out_running_valid_r;
  assign out_switched      = out_switched_r;

endmodule

/* hdl/round_robin_slice_scheduler.sv */
// Top level of the round-robin slice scheduler: front end, command queue
// and back end. Depends on rrss_pkg, rrss_front, rrss_queue and rrss_back.
//
//   Channel  Handshake          Carries
//   in_      in_valid/in_stall  func, priority_req, target_pid
//   out_     out_valid/out_stall status, new_pid, running_pid, running_valid,
//                               switched
//   cfg_     cfg_valid/cfg_ready slice register index and value
//
// In the back end, a tick without a switch and unused codes go straight to
// done; unblock passes through the target check first; create, enter and
// exit critical and slice-expiry ticks scan the slot table, and block checks
// the target and then scans. The scan visits one slot per cycle.
// Reset is synchronous and clears the slot table at once; no sweep follows.
// The command queue holds two requests, so input is taken while a result
// waits on out_stall until the queue is full; cfg_ready is always high.
module round_robin_slice_scheduler
  import rrss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [PRIO_W-1:0]    in_priority_req,
  input  logic [PID_W-1:0]     in_target_pid,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  out_status,
  output logic [PID_W-1:0]     out_new_pid,
  output logic [PID_W-1:0]     out_running_pid,
  output logic                 out_running_valid,
  output logic                 out_switched,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SLICE_W-1:0]   cfg_data
);

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  assign cfg_ready = 1'b1;

  rrss_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_priority_req (in_priority_req),
    .in_target_pid   (in_target_pid),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_cmd        (push_cmd)
  );

  rrss_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  rrss_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write         (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .pop_valid         (pop_valid),
    .pop_ready         (pop_ready),
    .pop_cmd           (pop_cmd),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_new_pid       (out_new_pid),
    .out_running_pid   (out_running_pid),
    .out_running_valid (out_running_valid),
    .out_switched      (out_switched)
  );

endmodule

/* hdl/rrss_checker.sv */
// Port-level checks for the round-robin slice scheduler, bound to the top.
// Depends on rrss_pkg for widths and status codes.
module rrss_checker
  import rrss_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] out_status,
  input logic [PID_W-1:0]    out_new_pid,
  input logic [PID_W-1:0]    out_running_pid,
  input logic                out_running_valid,
  input logic                out_switched
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("result dropped or changed while stalled");

  a_idle_pid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_running_valid |-> out_running_pid == '0)
    else $error("idle result reports a running slot");

  a_fail_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STATUS_OK |-> !out_switched && out_new_pid == '0)
    else $error("failed request changed the running slot or gave a slot");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == STATUS_OK || out_status == STATUS_FULL ||
                  out_status == STATUS_NOT_IN_USE)
    else $error("undefined status code");

endmodule

bind round_robin_slice_scheduler rrss_checker u_rrss_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_new_pid       (out_new_pid),
  .out_running_pid   (out_running_pid),
  .out_running_valid (out_running_valid),
  .out_switched      (out_switched)
);
